>>> src/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// shared widths, defaults and helpers of the markov miss prefetcher
// ----------------------------------------------------------------------------
package mmp_pkg;

	// fixed field widths of the two channels
	localparam int unsigned ADDR_W  = 58;
	localparam int unsigned META_W  = 32;
	localparam int unsigned SPACE_W = 3;

	// most prefetches one access may cause
	localparam int unsigned MAX_ISSUE = 4;

	// default table shape
	localparam int unsigned DEF_TABLE_SETS = 256;
	localparam int unsigned DEF_TABLE_WAYS = 4;
	localparam int unsigned DEF_SUCCESSORS = 4;
	localparam int unsigned DEF_BLOCK_BITS = 58;

	// index width for n things, at least one bit
	function automatic int unsigned idx_w(input int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

>>> src/mmp_req_if.sv
// ----------------------------------------------------------------------------
// mmp_req_if
// cache access channel into the prefetcher
// ----------------------------------------------------------------------------
interface mmp_req_if;
	import mmp_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  block_addr;
	logic               was_hit;
	logic [SPACE_W-1:0] queue_space;
	logic [META_W-1:0]  tag_data;

	modport source (output valid, block_addr, was_hit, queue_space, tag_data, input ready);
	modport sink   (input valid, block_addr, was_hit, queue_space, tag_data, output ready);
endinterface

>>> src/mmp_pf_if.sv
// ----------------------------------------------------------------------------
// mmp_pf_if
// prefetch request channel out of the prefetcher
// ----------------------------------------------------------------------------
interface mmp_pf_if;
	import mmp_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] prefetch_block;
	logic [META_W-1:0] tag_echo;
	logic              final_one;

	modport source (output valid, prefetch_block, tag_echo, final_one, input ready);
	modport sink   (input valid, prefetch_block, tag_echo, final_one, output ready);
endinterface

>>> src/mmp_ram.sv
// ----------------------------------------------------------------------------
// mmp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mmp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/mmp_row_unit.sv
// ----------------------------------------------------------------------------
// mmp_row_unit
// way compare, fill/victim choice and lru touch for one table row
// ----------------------------------------------------------------------------
module mmp_row_unit #(
	parameter int unsigned WAYS = mmp_pkg::DEF_TABLE_WAYS,
	parameter int unsigned BW   = mmp_pkg::DEF_BLOCK_BITS
) (
	input  logic [WAYS-1:0]                             used,
	input  logic [WAYS-1:0][mmp_pkg::idx_w(WAYS)-1:0]   age,
	input  logic [WAYS-1:0][BW-1:0]                     tag,
	input  logic [BW-1:0]                               key,
	output logic                                        hit,
	output logic [mmp_pkg::idx_w(WAYS)-1:0]             way,
	output logic [WAYS-1:0][mmp_pkg::idx_w(WAYS)-1:0]   new_age
);
	import mmp_pkg::*;

	localparam int unsigned WW = idx_w(WAYS);
	localparam int unsigned RK = $clog2(WAYS + 1);

	logic [WAYS-1:0] match;
	logic [WW-1:0]   hit_way;
	logic [WW-1:0]   inv_way;
	logic [WW-1:0]   old_way;
	logic            any_inv;
	logic [RK-1:0]   rank;

	always_comb begin
		hit_way = '0;
		inv_way = '0;
		any_inv = 1'b0;
		old_way = '0;
		for (int i = 0; i < WAYS; i++) begin
			match[i] = used[i] && (tag[i] == key);
		end
		// lowest matching way and lowest free way win
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WW'(i);
			end
			if (!used[i]) begin
				inv_way = WW'(i);
				any_inv = 1'b1;
			end
		end
		// oldest way, first one on a tie
		for (int i = 1; i < WAYS; i++) begin
			if (age[i] > age[old_way]) begin
				old_way = WW'(i);
			end
		end
		hit = |match;
		priority if (hit) begin
			way  = hit_way;
			rank = RK'(age[hit_way]);
		end else if (any_inv) begin
			way  = inv_way;
			rank = RK'(WAYS);
		end else begin
			way  = old_way;
			rank = RK'(age[old_way]);
		end
		// ways younger than the touched one age by one
		for (int i = 0; i < WAYS; i++) begin
			if (WW'(i) == way) begin
				new_age[i] = '0;
			end else if (used[i] && (RK'(age[i]) < rank)) begin
				new_age[i] = age[i] + 1'b1;
			end else begin
				new_age[i] = age[i];
			end
		end
	end
endmodule

>>> src/markov_miss_prefetcher.sv
// ----------------------------------------------------------------------------
// markov_miss_prefetcher
// correlation table prefetcher trained on the cache miss stream
// ----------------------------------------------------------------------------
// One access is taken at a time. A hit is dropped in the cycle it is taken.
// A miss looks its block up in a set-associative correlation table, sends
// the valid successors of a hit entry (newest first, never the block itself,
// no more than the queue space, four at most) and then trains the entry of
// the previous miss with this block. The table rows live in one ram, the
// successor lists in another; one row unit does way compare, victim choice
// and lru update for both the lookup and the training pass. With a power of
// two set count a miss whose block is in the table keeps the block busy
// for the row read and compare, one successor list read, one successor slot
// checked per cycle and then training and write-back. A miss whose block is
// not found skips the successor steps; the first miss after reset also skips
// training. A stalled prefetch output adds its wait. Any other set count adds
// a set index reduction step, one 16-bit digit at a time by reciprocal
// multiplication. After reset the row ram is cleared one set per cycle, and
// no access is taken until that is done.
// ----------------------------------------------------------------------------
module markov_miss_prefetcher #(
	parameter int unsigned TABLE_SETS = mmp_pkg::DEF_TABLE_SETS,
	parameter int unsigned TABLE_WAYS = mmp_pkg::DEF_TABLE_WAYS,
	parameter int unsigned SUCCESSORS = mmp_pkg::DEF_SUCCESSORS,
	parameter int unsigned BLOCK_BITS = mmp_pkg::DEF_BLOCK_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	mmp_req_if.sink   req,
	mmp_pf_if.source  pf
);
	import mmp_pkg::*;

	localparam int unsigned BW     = BLOCK_BITS;
	localparam int unsigned WW     = idx_w(TABLE_WAYS);
	localparam int unsigned SW     = idx_w(TABLE_SETS);
	localparam int unsigned EW     = idx_w(TABLE_SETS * TABLE_WAYS);
	localparam int unsigned KW     = idx_w(SUCCESSORS);
	localparam int unsigned ND     = (BW + 15) / 16;
	localparam int unsigned DW     = idx_w(ND);
	localparam int unsigned RL     = $clog2(TABLE_SETS);
	localparam longint unsigned MREC_L =
		((64'd1 << (32 + RL)) + 64'(TABLE_SETS) - 64'd1) / 64'(TABLE_SETS);
	localparam logic [32:0] MREC   = 33'(MREC_L);
	localparam int unsigned ROW_W  = TABLE_WAYS * (1 + WW + BW);
	localparam int unsigned SUCC_W = SUCCESSORS * (BW + 1);
	localparam bit          SETS_POW2 = (TABLE_SETS & (TABLE_SETS - 1)) == 0;

	// sequencer, one-hot
	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001, // sweep the row ram after reset
		S_IDLE  = 14'b00000000000010, // wait for an access
		S_MOD   = 14'b00000000000100, // set index reduction, one digit at a time
		S_LK1   = 14'b00000000001000, // row read of the current block
		S_LK2   = 14'b00000000010000, // capture the row
		S_LK3   = 14'b00000000100000, // compare, touch, write the row back
		S_SRD   = 14'b00000001000000, // successor list read
		S_ISSUE = 14'b00000010000000, // one successor slot per cycle unless the output stalls
		S_TR0   = 14'b00000100000000, // start training, if there is a previous miss
		S_TR1   = 14'b00001000000000, // row read of the previous miss
		S_TR2   = 14'b00010000000000, // capture the row
		S_TR3   = 14'b00100000000000, // lookup of the previous miss
		S_TR4   = 14'b01000000000000, // its successor list read
		S_TR5   = 14'b10000000000000  // train and write back
	} state_t;

	state_t               state_q;
	logic [BW-1:0]        cur_q;
	logic [SPACE_W-1:0]   space_q;
	logic [META_W-1:0]    meta_q;
	logic [SW-1:0]        cur_set_q;
	logic [BW-1:0]        prev_q;
	logic [SW-1:0]        prev_set_q;
	logic                 prev_known_q;
	logic [SW-1:0]        tag_raddr_q;
	logic [EW-1:0]        succ_addr_q;
	logic [DW-1:0]        mod_cnt_q;
	logic                 mod_ph_q;
	logic [31:0]          mod_quo_q;
	logic [SW-1:0]        clr_q;
	logic [KW-1:0]        k_q;
	logic [SPACE_W-1:0]   cnt_q;
	logic                 p_hit_q;

	// working copy of the row under lookup
	logic [TABLE_WAYS-1:0]           row_used_q;
	logic [TABLE_WAYS-1:0][WW-1:0]   row_age_q;
	logic [TABLE_WAYS-1:0][BW-1:0]   row_tag_q;

	// output register
	logic                 pf_valid_q;
	logic [ADDR_W-1:0]    pf_block_q;
	logic [META_W-1:0]    pf_meta_q;
	logic                 pf_final_q;

	// ram ports
	logic                 tag_we;
	logic [SW-1:0]        tag_waddr;
	logic [ROW_W-1:0]     tag_wdata;
	logic [ROW_W-1:0]     tag_rdata;
	logic                 succ_we;
	logic [EW-1:0]        succ_waddr;
	logic [SUCC_W-1:0]    succ_wdata;
	logic [SUCC_W-1:0]    succ_rdata;

	logic [TABLE_WAYS-1:0]           rd_used;
	logic [TABLE_WAYS-1:0][WW-1:0]   rd_age;
	logic [TABLE_WAYS-1:0][BW-1:0]   rd_tag;
	logic [SUCCESSORS-1:0]           s_used;
	logic [SUCCESSORS-1:0][BW-1:0]   s_blk;

	// row unit
	logic [BW-1:0]                   key;
	logic                            ru_hit;
	logic [WW-1:0]                   ru_way;
	logic [TABLE_WAYS-1:0][WW-1:0]   ru_age;

	// issue and training
	logic [BW-1:0]                   blk_in;
	logic [SW-1:0]                   set_in;
	logic [ND-1:0][15:0]             cur_dig;
	logic [31:0]                     mod_v;
	logic [64:0]                     mod_prod;
	logic [31:0]                     mod_quo;
	logic [31:0]                     mod_rem;
	logic [SUCCESSORS-1:0]           elig;
	logic [SUCCESSORS-1:0]           elig_rest;
	logic                            take;
	logic                            out_free;
	logic                            emit;
	logic                            last_one;
	logic [SUCCESSORS-1:0]           o_used;
	logic [SUCCESSORS-1:0]           n_used;
	logic [SUCCESSORS-1:0][BW-1:0]   n_blk;
	logic [KW-1:0]                   pos;
	logic [TABLE_WAYS-1:0]           wr_used;
	logic [TABLE_WAYS-1:0][BW-1:0]   wr_tag;

	assign {rd_used, rd_age, rd_tag} = tag_rdata;
	assign {s_used, s_blk}           = succ_rdata;

	mmp_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_SETS)) u_row_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (tag_raddr_q),
		.rdata (tag_rdata)
	);

	mmp_ram #(.WIDTH(SUCC_W), .DEPTH(TABLE_SETS * TABLE_WAYS)) u_succ_ram (
		.clk   (clk),
		.we    (succ_we),
		.waddr (succ_waddr),
		.wdata (succ_wdata),
		.raddr (succ_addr_q),
		.rdata (succ_rdata)
	);

	// lookup key is the current block, training key the previous miss
	assign key = (state_q == S_LK3) ? cur_q : prev_q;

	mmp_row_unit #(.WAYS(TABLE_WAYS), .BW(BW)) u_row (
		.used    (row_used_q),
		.age     (row_age_q),
		.tag     (row_tag_q),
		.key     (key),
		.hit     (ru_hit),
		.way     (ru_way),
		.new_age (ru_age)
	);

	// set index of a new access when the set count is a power of two
	assign blk_in = BW'(req.block_addr);
	assign set_in = SW'(blk_in & BW'(TABLE_SETS - 1));

	// one digit of the set index reduction: remainder so far and next 16 bits,
	// quotient by reciprocal multiplication, then remainder from the quotient
	assign cur_dig  = (ND * 16)'(cur_q);
	assign mod_v    = {16'(cur_set_q), cur_dig[mod_cnt_q]};
	assign mod_prod = 65'(mod_v) * 65'(MREC);
	assign mod_quo  = 32'(mod_prod >> (32 + RL));
	assign mod_rem  = mod_v - mod_quo_q * 32'(TABLE_SETS);

	// successor slots worth sending, and what is left after this slot
	always_comb begin
		for (int k = 0; k < SUCCESSORS; k++) begin
			elig[k] = s_used[k] && (s_blk[k] != cur_q);
		end
		elig_rest = (elig >> k_q) >> 1;
	end

	assign take     = (state_q == S_ISSUE) && elig[k_q] && (cnt_q < space_q);
	assign out_free = !pf_valid_q || pf.ready;
	assign emit     = take && out_free;
	assign last_one = ((cnt_q + 1'b1) == space_q) || (elig_rest == '0);

	// training: move a known successor to the front, else shift all down
	always_comb begin
		o_used = p_hit_q ? s_used : '0;
		pos    = KW'(SUCCESSORS - 1);
		for (int k = SUCCESSORS - 1; k >= 0; k--) begin
			if (o_used[k] && (s_blk[k] == cur_q)) begin
				pos = KW'(k);
			end
		end
		for (int k = 0; k < SUCCESSORS; k++) begin
			if (k == 0) begin
				n_blk[k]  = cur_q;
				n_used[k] = 1'b1;
			end else if (KW'(k) <= pos) begin
				n_blk[k]  = s_blk[k - 1];
				n_used[k] = o_used[k - 1];
			end else begin
				n_blk[k]  = s_blk[k];
				n_used[k] = o_used[k];
			end
		end
	end

	// row write data: clear, lru touch after lookup, or write-back of the trained way
	always_comb begin
		wr_used = row_used_q;
		wr_tag  = row_tag_q;
		if (state_q == S_TR5) begin
			wr_used[ru_way] = 1'b1;
			wr_tag[ru_way]  = prev_q;
		end
	end

	assign tag_we    = (state_q == S_CLEAR) || ((state_q == S_LK3) && ru_hit)
	                   || (state_q == S_TR5);
	assign tag_waddr = (state_q == S_CLEAR) ? clr_q
	                   : ((state_q == S_LK3) ? cur_set_q : prev_set_q);
	assign tag_wdata = (state_q == S_CLEAR) ? '0 : {wr_used, ru_age, wr_tag};

	assign succ_we    = (state_q == S_TR5);
	assign succ_waddr = EW'(EW'(prev_set_q) * EW'(TABLE_WAYS) + EW'(ru_way));
	assign succ_wdata = {n_used, n_blk};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			prev_known_q <= 1'b0;
			prev_q       <= '0;
			prev_set_q   <= '0;
			cnt_q        <= '0;
			space_q      <= '0;
			k_q          <= '0;
			p_hit_q      <= 1'b0;
			mod_ph_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == SW'(TABLE_SETS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid && !req.was_hit) begin
						cur_q     <= blk_in;
						meta_q    <= req.tag_data;
						space_q   <= (req.queue_space > SPACE_W'(MAX_ISSUE))
						             ? SPACE_W'(MAX_ISSUE) : req.queue_space;
						mod_cnt_q <= DW'(ND - 1);
						mod_ph_q  <= 1'b0;
						if (SETS_POW2) begin
							cur_set_q   <= set_in;
							tag_raddr_q <= set_in;
							state_q     <= S_LK1;
						end else begin
							cur_set_q <= '0;
							state_q   <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (!mod_ph_q) begin
						mod_quo_q <= mod_quo;
						mod_ph_q  <= 1'b1;
					end else begin
						mod_ph_q  <= 1'b0;
						cur_set_q <= SW'(mod_rem);
						if (mod_cnt_q == '0) begin
							tag_raddr_q <= SW'(mod_rem);
							state_q     <= S_LK1;
						end else begin
							mod_cnt_q <= mod_cnt_q - 1'b1;
						end
					end
				end
				S_LK1: state_q <= S_LK2;
				S_LK2: begin
					row_used_q <= rd_used;
					row_age_q  <= rd_age;
					row_tag_q  <= rd_tag;
					state_q    <= S_LK3;
				end
				S_LK3: begin
					if (ru_hit) begin
						row_age_q   <= ru_age;
						succ_addr_q <= EW'(EW'(cur_set_q) * EW'(TABLE_WAYS) + EW'(ru_way));
						state_q     <= S_SRD;
					end else begin
						state_q <= S_TR0;
					end
				end
				S_SRD: begin
					k_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					if (!take || out_free) begin
						if (emit) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (k_q == KW'(SUCCESSORS - 1)) begin
							state_q <= S_TR0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_TR0: begin
					if (prev_known_q) begin
						tag_raddr_q <= prev_set_q;
						state_q     <= S_TR1;
					end else begin
						prev_q       <= cur_q;
						prev_set_q   <= cur_set_q;
						prev_known_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_TR1: state_q <= S_TR2;
				S_TR2: begin
					row_used_q <= rd_used;
					row_age_q  <= rd_age;
					row_tag_q  <= rd_tag;
					state_q    <= S_TR3;
				end
				S_TR3: begin
					p_hit_q <= ru_hit;
					if (ru_hit) begin
						row_age_q <= ru_age;
					end
					succ_addr_q <= EW'(EW'(prev_set_q) * EW'(TABLE_WAYS) + EW'(ru_way));
					state_q     <= S_TR4;
				end
				S_TR4: state_q <= S_TR5;
				S_TR5: begin
					prev_q       <= cur_q;
					prev_set_q   <= cur_set_q;
					prev_known_q <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register, refilled in the cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				pf_valid_q <= 1'b1;
			end else if (pf.ready) begin
				pf_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pf_block_q <= ADDR_W'(s_blk[k_q]);
			pf_meta_q  <= meta_q;
			pf_final_q <= last_one;
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign pf.valid          = pf_valid_q;
	assign pf.prefetch_block = pf_block_q;
	assign pf.tag_echo       = pf_meta_q;
	assign pf.final_one      = pf_final_q;

`ifndef SYNTHESIS
	// never more prefetches than the queue space allows
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> (cnt_q <= space_q))
		else $error("prefetch count above queue space");

	// a miss keeps the block busy in the next cycle
	a_miss_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !req.was_hit) |=> !req.ready)
		else $error("ready right after a miss");

	// once a miss has been seen there is always a previous miss
	a_prev_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(prev_known_q))
		else $error("previous miss lost");

	// a prefetch only enters the register while scanning successors
	a_emit_scan: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (state_q == S_ISSUE) && (cnt_q < SPACE_W'(MAX_ISSUE)))
		else $error("prefetch outside the successor scan");
`endif
endmodule

>>> tb/tb_markov_miss_prefetcher.sv
// ----------------------------------------------------------------------------
// tb_markov_miss_prefetcher
// self-checking bench: directed and random cache accesses are driven in,
// every prefetch item is checked against a behavioural table predictor
// ----------------------------------------------------------------------------
module tb_markov_miss_prefetcher;
	import mmp_pkg::*;

	localparam int unsigned SETS  = DEF_TABLE_SETS;
	localparam int unsigned WAYS  = DEF_TABLE_WAYS;
	localparam int unsigned SUCC  = DEF_SUCCESSORS;
	localparam int unsigned NROWS = SETS * WAYS;

	typedef struct packed {
		logic [ADDR_W-1:0]  blk;
		logic               hit;
		logic [SPACE_W-1:0] space;
		logic [META_W-1:0]  meta;
	} access_t;

	typedef struct packed {
		logic [ADDR_W-1:0] blk;
		logic [META_W-1:0] meta;
		logic              last;
	} pf_t;

	logic clk;
	logic arst_n;

	mmp_req_if req ();
	mmp_pf_if  pf ();

	markov_miss_prefetcher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.pf     (pf.source)
	);

	// clock, 10 units
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state: a copy of the correlation table
	logic [ADDR_W-1:0] row_tag  [NROWS];
	logic              row_used [NROWS];
	int unsigned       row_age  [NROWS];
	logic [ADDR_W-1:0] succ_blk [NROWS*SUCC];
	logic              succ_ok  [NROWS*SUCC];
	logic [ADDR_W-1:0] prev_blk;
	logic              prev_blk_ok;

	access_t     pending_acc[$];
	pf_t         expected_pf[$];
	int          n_errors;
	int          n_sent;
	int          n_total;
	bit          calm;
	int unsigned hold_cycles;
	bit          hold_req;
	bit          gate_send;

	// move way w of set s to the front of the lru order
	function automatic void lru_touch(int unsigned s, int unsigned w, int unsigned old);
		for (int unsigned i = 0; i < WAYS; i++)
			if (i != w && row_used[s*WAYS+i] && row_age[s*WAYS+i] < old)
				row_age[s*WAYS+i]++;
		row_age[s*WAYS+w] = 0;
	endfunction

	function automatic int row_find(logic [ADDR_W-1:0] b);
		int unsigned s;
		s = 32'(b % SETS);
		for (int unsigned i = 0; i < WAYS; i++)
			if (row_used[s*WAYS+i] && row_tag[s*WAYS+i] == b) begin
				lru_touch(s, i, row_age[s*WAYS+i]);
				return s*WAYS + i;
			end
		return -1;
	endfunction

	function automatic void row_store(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] sb[SUCC],
			logic su[SUCC]);
		int unsigned s, w, rk;
		s = 32'(b % SETS);
		w = WAYS;
		rk = WAYS;
		for (int unsigned i = 0; i < WAYS && w == WAYS; i++)
			if (row_used[s*WAYS+i] && row_tag[s*WAYS+i] == b) begin
				w = i;
				rk = row_age[s*WAYS+i];
			end
		for (int unsigned i = 0; i < WAYS && w == WAYS; i++)
			if (!row_used[s*WAYS+i]) begin
				w = i;
				rk = WAYS;
			end
		if (w == WAYS) begin
			w = 0;
			for (int unsigned i = 1; i < WAYS; i++)
				if (row_age[s*WAYS+i] > row_age[s*WAYS+w])
					w = i;
			rk = row_age[s*WAYS+w];
		end
		lru_touch(s, w, rk);
		row_used[s*WAYS+w] = 1'b1;
		row_tag[s*WAYS+w]  = b;
		for (int unsigned k = 0; k < SUCC; k++) begin
			succ_blk[(s*WAYS+w)*SUCC+k] = sb[k];
			succ_ok[(s*WAYS+w)*SUCC+k]  = su[k];
		end
	endfunction

	// work out the prefetches of one access and train the table
	function automatic void predict_prefetches(access_t a);
		int          h, p;
		int unsigned lim, n, pos;
		logic [ADDR_W-1:0] sb[SUCC];
		logic              su[SUCC];
		pf_t         r;
		if (a.hit)
			return;
		lim = (32'(a.space) > MAX_ISSUE) ? MAX_ISSUE : 32'(a.space);
		n = 0;
		h = row_find(a.blk);
		if (h >= 0)
			for (int unsigned k = 0; k < SUCC && n < lim; k++) begin
				if (!succ_ok[h*SUCC+k] || succ_blk[h*SUCC+k] == a.blk)
					continue;
				r.blk  = succ_blk[h*SUCC+k];
				r.meta = a.meta;
				r.last = 1'b0;
				expected_pf.push_back(r);
				n++;
			end
		if (n > 0)
			expected_pf[$].last = 1'b1;
		if (prev_blk_ok) begin
			p = row_find(prev_blk);
			for (int unsigned k = 0; k < SUCC; k++) begin
				sb[k] = (p >= 0) ? succ_blk[p*SUCC+k] : '0;
				su[k] = (p >= 0) ? succ_ok[p*SUCC+k] : 1'b0;
			end
			pos = SUCC;
			for (int unsigned k = 0; k < SUCC && pos == SUCC; k++)
				if (su[k] && sb[k] == a.blk)
					pos = k;
			if (pos == SUCC)
				pos = SUCC - 1;
			for (int unsigned k = pos; k > 0; k--) begin
				sb[k] = sb[k-1];
				su[k] = su[k-1];
			end
			sb[0] = a.blk;
			su[0] = 1'b1;
			row_store(prev_blk, sb, su);
		end
		prev_blk    = a.blk;
		prev_blk_ok = 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		n_errors++;
	endtask

	function automatic access_t mk(logic [ADDR_W-1:0] b, bit h, int unsigned sp,
			logic [META_W-1:0] m);
		access_t a;
		a.blk = b;
		a.hit = h;
		a.space = sp[SPACE_W-1:0];
		a.meta = m;
		return a;
	endfunction

	// random block from a small pool so that the table gets hits,
	// with same-set aliases that force lru victims
	function automatic logic [ADDR_W-1:0] pick_block();
		logic [ADDR_W-1:0] b;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			b = ADDR_W'({$urandom, $urandom});
		else
			b = ADDR_W'($urandom_range(0, 5)) * SETS + ADDR_W'($urandom_range(0, 3))
				+ (($urandom_range(0, 1) != 0) ? {2'b11, 56'h0} : '0);
		return b;
	endfunction

	// driver: offers the oldest pending item, idles in bursts
	int unsigned send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.block_addr  <= '0;
			req.was_hit     <= 1'b0;
			req.queue_space <= '0;
			req.tag_data    <= '0;
			send_gap        <= 0;
		end else begin
			if (req.valid && req.ready) begin
				predict_prefetches(pending_acc.pop_front());
				n_sent <= n_sent + 1;
			end
			if (send_gap != 0) begin
				send_gap  <= send_gap - 1;
				req.valid <= 1'b0;
			end else if ((!req.valid || req.ready) && !calm && $urandom_range(0, 9) == 0) begin
				send_gap  <= $urandom_range(1, 17);
				req.valid <= 1'b0;
			end else if (!(req.valid && !req.ready) && (pending_acc.size() == 0 || gate_send)) begin
				req.valid <= 1'b0;
			end else if (!(req.valid && !req.ready)) begin
				req.valid       <= 1'b1;
				req.block_addr  <= pending_acc[0].blk;
				req.was_hit     <= pending_acc[0].hit;
				req.queue_space <= pending_acc[0].space;
				req.tag_data    <= pending_acc[0].meta;
			end
		end
	end

	// monitor: stalls in bursts, and once for a long stretch
	int unsigned stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf.ready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (pf.valid && pf.ready) begin
				if (expected_pf.size() == 0) begin
					report_mismatch("unexpected prefetch", 64'(pf.prefetch_block), 64'h0);
				end else begin
					if (pf.prefetch_block !== expected_pf[0].blk)
						report_mismatch("prefetch_block", 64'(pf.prefetch_block),
							64'(expected_pf[0].blk));
					if (pf.tag_echo !== expected_pf[0].meta)
						report_mismatch("tag_echo", 64'(pf.tag_echo), 64'(expected_pf[0].meta));
					if (pf.final_one !== expected_pf[0].last)
						report_mismatch("final_one", 64'(pf.final_one), 64'(expected_pf[0].last));
					void'(expected_pf.pop_front());
				end
			end
			if (hold_req) begin
				pf.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				pf.ready   <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 17);
				pf.ready   <= 1'b0;
			end else begin
				pf.ready <= 1'b1;
			end
		end
	end

	// long receiver hold, counted in its own process
	initial begin
		hold_req = 1'b0;
		wait (n_sent >= 60);
		@(posedge clk);
		hold_req <= 1'b1;
		repeat (hold_cycles) @(posedge clk);
		hold_req <= 1'b0;
	end

	// stimulus
	initial begin
		logic [ADDR_W-1:0] b;
		logic [ADDR_W-1:0] ring[$];
		n_errors = 0;
		n_sent = 0;
		calm = 1'b0;
		gate_send = 1'b0;
		hold_cycles = 300;
		for (int unsigned i = 0; i < NROWS; i++) begin
			row_used[i] = 1'b0;
			row_age[i]  = 0;
			row_tag[i]  = '0;
		end
		for (int unsigned i = 0; i < NROWS*SUCC; i++) begin
			succ_ok[i]  = 1'b0;
			succ_blk[i] = '0;
		end
		prev_blk = '0;
		prev_blk_ok = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, hits, zero and oversize queue space, repeated miss
		pending_acc.push_back(mk('0, 0, 4, '0));
		pending_acc.push_back(mk({ADDR_W{1'b1}}, 0, 4, '1));
		pending_acc.push_back(mk('0, 0, 4, 32'h5555_aaaa));
		pending_acc.push_back(mk({ADDR_W{1'b1}}, 1, 4, 32'h1));
		pending_acc.push_back(mk('0, 0, 7, 32'haaaa_5555));
		pending_acc.push_back(mk('0, 0, 7, 32'h2));
		pending_acc.push_back(mk(58'h2aa_aaaa_aaaa_aaaa, 0, 0, 32'h3));
		pending_acc.push_back(mk('0, 0, 0, 32'h4));
		pending_acc.push_back(mk(58'h155_5555_5555_5555, 0, 5, 32'h5));
		pending_acc.push_back(mk('0, 0, 6, 32'h6));
		pending_acc.push_back(mk('0, 0, 1, 32'h7));
		pending_acc.push_back(mk('0, 0, 2, 32'h8));
		pending_acc.push_back(mk('0, 0, 3, 32'h9));
		pending_acc.push_back(mk('0, 1, 7, 32'ha));
		n_total = 14;
		// sender pause until every prefetch has come
		wait (pending_acc.size() == 0 && !req.valid);
		gate_send = 1'b1;
		wait (expected_pf.size() == 0);
		repeat (40) @(posedge clk);
		gate_send = 1'b0;

		// random: mostly a repeating miss loop so chains get trained
		while (n_total < 210) begin
			if ($urandom_range(0, 3) != 0) begin
				ring.delete();
				for (int i = $urandom_range(2, 6); i > 0; i--)
					ring.push_back(pick_block());
				for (int r = $urandom_range(2, 4); r > 0; r--)
					foreach (ring[j]) begin
						pending_acc.push_back(mk(ring[j], 0, $urandom_range(0, 7), $urandom));
						n_total++;
					end
			end else begin
				b = pick_block();
				pending_acc.push_back(mk(b, $urandom_range(0, 1), $urandom_range(0, 7),
					$urandom));
				n_total++;
			end
			if (n_total > 170)
				calm = 1'b1;
			wait (pending_acc.size() < 8);
		end
		calm = 1'b1;
		wait (pending_acc.size() == 0 && !req.valid);
		wait (expected_pf.size() == 0);
		repeat (200) @(posedge clk);
		if (n_errors == 0 && expected_pf.size() == 0)
			$display("[markov_miss_prefetcher] OK");
		else
			$display("[markov_miss_prefetcher] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("[markov_miss_prefetcher] ERROR");
		$finish;
	end

endmodule

>>> files.f
src/mmp_pkg.sv
src/mmp_req_if.sv
src/mmp_pf_if.sv
src/mmp_ram.sv
src/mmp_row_unit.sv
src/markov_miss_prefetcher.sv
tb/tb_markov_miss_prefetcher.sv
